// File: rtl/rfbt_pkg.sv
// Shared types and constants for the ring FIFO with block transfers.
package rfbt_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W = 64;
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		CMD_WRITE_ONE   = 2'd0,
		CMD_READ_ONE    = 2'd1,
		CMD_BLOCK_READ  = 2'd2,
		CMD_BLOCK_WRITE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_BLK_ISSUE,
		ST_BLK_LOAD
	} state_t;

	typedef enum logic [1:0] {
		GR_NONE,
		GR_WRITE,
		GR_BLOCK
	} gr_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic    push;
		logic    pop;
		logic    blk_start;
		logic    paste_set;
		logic    paste_dec;
		logic    paste_clr;
		logic    out_load;
		logic    out_from_mem;
		logic    out_status;
		gr_sel_t out_gr;
		logic    out_last;
	} ctrl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic word_zero;
		logic full;
		logic fill_zero;
		logic rd_grant_zero;
		logic wr_grant_zero;
		logic paste_zero;
		logic blk_done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/rfbt_dp.sv
// Datapath: ring memory, indices, counters, capacity and result register.
module rfbt_dp #(
	parameter int DEPTH = rfbt_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rfbt_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic [rfbt_pkg::WORD_W-1:0]   item_value,
	input  logic [rfbt_pkg::CNT_W-1:0]    block_len,
	input  logic                          up_to,
	input  logic                          out_ready,
	input  rfbt_pkg::ctrl_cmd_t           cmd,
	output rfbt_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	output logic [rfbt_pkg::WORD_W-1:0]   read_value,
	output logic                          status,
	output logic [rfbt_pkg::CNT_W-1:0]    granted,
	output logic                          last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW = rfbt_pkg::CNT_W;

	logic [rfbt_pkg::WORD_W-1:0] mem [DEPTH];
	logic [rfbt_pkg::WORD_W-1:0] rd_data_q;
	logic [IDX_W-1:0]            rd_idx_q, wr_idx_q;
	logic [CW-1:0]               fill_q, paste_q, cap_q, blk_cnt_q, blk_total_q;
	logic                        out_valid_q;
	logic [rfbt_pkg::WORD_W-1:0] read_value_q;
	logic                        status_q, last_q;
	logic [CW-1:0]               granted_q;
	logic [CW-1:0]               rd_grant, wr_grant, cap_sat;
	logic [IDX_W-1:0]            rd_idx_nxt, wr_idx_nxt;

	// Grant for a block request against avail entries; zero means refused.
	function automatic logic [CW-1:0] grant_count(input logic [CW-1:0] len,
			input logic upto, input logic [CW-1:0] avail);
		logic [CW-1:0] g;
		if (len == '0) begin
			g = '0;
		end else if (!upto) begin
			g = (len > avail) ? '0 : len;
		end else begin
			g = (len < avail) ? len : avail;
		end
		return g;
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [CW-1:0] cap);
		logic [CW-1:0] n;
		n = CW'(i) + CW'(1);
		return (n >= cap) ? '0 : n[IDX_W-1:0];
	endfunction

	assign rd_grant   = grant_count(block_len, up_to, fill_q);
	assign wr_grant   = grant_count(block_len, up_to, cap_q - fill_q);
	assign rd_idx_nxt = next_idx(rd_idx_q, cap_q);
	assign wr_idx_nxt = next_idx(wr_idx_q, cap_q);

	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_sat = CW'(1);
		end else if (cfg_wr_data > CW'(DEPTH)) begin
			cap_sat = CW'(DEPTH);
		end else begin
			cap_sat = cfg_wr_data;
		end
	end

	always_comb begin
		stat.word_zero     = (item_value == '0);
		stat.full          = (fill_q >= cap_q);
		stat.fill_zero     = (fill_q == '0);
		stat.rd_grant_zero = (rd_grant == '0);
		stat.wr_grant_zero = (wr_grant == '0);
		stat.paste_zero    = (paste_q == '0);
		stat.blk_done      = (blk_cnt_q == '0);
		stat.out_free      = !out_valid_q || out_ready;
	end

	// Ring memory, registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_idx_q] <= item_value;
		end
		if (cmd.pop) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			fill_q    <= '0;
			paste_q   <= '0;
			cap_q     <= CW'(DEPTH);
			blk_cnt_q <= '0;
		end else if (cfg_wr_en) begin
			cap_q    <= cap_sat;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			fill_q   <= '0;
			paste_q  <= '0;
		end else begin
			if (cmd.push) begin
				wr_idx_q <= wr_idx_nxt;
			end
			if (cmd.pop) begin
				rd_idx_q <= rd_idx_nxt;
			end
			if (cmd.push && !cmd.pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.pop && !cmd.push) begin
				fill_q <= fill_q - CW'(1);
			end
			priority if (cmd.paste_clr) begin
				paste_q <= '0;
			end else if (cmd.paste_set) begin
				paste_q <= wr_grant - CW'(1);
			end else if (cmd.paste_dec) begin
				paste_q <= paste_q - CW'(1);
			end
			priority if (cmd.blk_start) begin
				blk_cnt_q <= rd_grant;
			end else if (cmd.pop && !stat.blk_done) begin
				blk_cnt_q <= blk_cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.blk_start) begin
			blk_total_q <= rd_grant;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_value_q <= cmd.out_from_mem ? rd_data_q : '0;
			status_q     <= cmd.out_status;
			last_q       <= cmd.out_last;
			unique case (cmd.out_gr)
				rfbt_pkg::GR_WRITE: granted_q <= wr_grant;
				rfbt_pkg::GR_BLOCK: granted_q <= blk_total_q;
				default:            granted_q <= '0;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign granted    = granted_q;
	assign last       = last_q;

	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q) else $error("fill exceeds capacity");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> fill_q < cap_q) else $error("push into full ring");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> fill_q != '0) else $error("pop from empty ring");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

endmodule

// File: rtl/rfbt_ctrl.sv
// Controller state machine: decodes requests and sequences block reads.
module rfbt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic                 block_first,
	input  rfbt_pkg::dp_stat_t   stat,
	output rfbt_pkg::ctrl_cmd_t  cmd
);

	rfbt_pkg::state_t state_q, state_nxt;
	rfbt_pkg::cmd_t   op;
	logic             accept;

	assign op       = rfbt_pkg::cmd_t'(command);
	assign in_ready = (state_q == rfbt_pkg::ST_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfbt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rfbt_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == rfbt_pkg::CMD_READ_ONE && !stat.fill_zero) begin
						state_nxt = rfbt_pkg::ST_READ;
					end else if (op == rfbt_pkg::CMD_BLOCK_READ && !stat.rd_grant_zero) begin
						state_nxt = rfbt_pkg::ST_BLK_ISSUE;
					end
				end
			end
			rfbt_pkg::ST_READ: state_nxt = rfbt_pkg::ST_IDLE;
			rfbt_pkg::ST_BLK_ISSUE: begin
				if (stat.out_free) begin
					state_nxt = rfbt_pkg::ST_BLK_LOAD;
				end
			end
			rfbt_pkg::ST_BLK_LOAD: begin
				state_nxt = stat.blk_done ? rfbt_pkg::ST_IDLE : rfbt_pkg::ST_BLK_ISSUE;
			end
			default: state_nxt = rfbt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_gr = rfbt_pkg::GR_NONE;
		unique case (state_q)
			rfbt_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.paste_clr = (op != rfbt_pkg::CMD_BLOCK_WRITE);
					cmd.out_last  = 1'b1;
					unique case (op)
						rfbt_pkg::CMD_WRITE_ONE: begin
							cmd.out_load = 1'b1;
							if (stat.word_zero || stat.full) begin
								cmd.out_status = 1'b1;
							end else begin
								cmd.push = 1'b1;
							end
						end
						rfbt_pkg::CMD_READ_ONE: begin
							if (stat.fill_zero) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = 1'b1;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						rfbt_pkg::CMD_BLOCK_READ: begin
							if (stat.rd_grant_zero) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = 1'b1;
							end else begin
								cmd.blk_start = 1'b1;
							end
						end
						default: begin
							cmd.out_load = 1'b1;
							if (block_first) begin
								if (stat.wr_grant_zero) begin
									cmd.paste_clr  = 1'b1;
									cmd.out_status = 1'b1;
								end else begin
									cmd.push      = 1'b1;
									cmd.paste_set = 1'b1;
									cmd.out_gr    = rfbt_pkg::GR_WRITE;
								end
							end else if (stat.paste_zero || stat.full) begin
								cmd.paste_clr  = 1'b1;
								cmd.out_status = 1'b1;
							end else begin
								cmd.push      = 1'b1;
								cmd.paste_dec = 1'b1;
							end
						end
					endcase
				end
			end
			rfbt_pkg::ST_READ: begin
				cmd.out_load     = 1'b1;
				cmd.out_from_mem = 1'b1;
				cmd.out_last     = 1'b1;
			end
			rfbt_pkg::ST_BLK_ISSUE: begin
				cmd.pop = stat.out_free;
			end
			rfbt_pkg::ST_BLK_LOAD: begin
				cmd.out_load     = 1'b1;
				cmd.out_from_mem = 1'b1;
				cmd.out_gr       = rfbt_pkg::GR_BLOCK;
				cmd.out_last     = stat.blk_done;
			end
			default: cmd = '0;
		endcase
	end

	a_idle_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rfbt_pkg::ST_READ |=> state_q == rfbt_pkg::ST_IDLE)
		else $error("single read did not complete");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != rfbt_pkg::ST_IDLE |-> !in_ready)
		else $error("request taken while busy");
	a_load_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rfbt_pkg::ST_BLK_LOAD |-> $past(cmd.pop))
		else $error("block load without memory read");

endmodule

// File: rtl/ring_fifo_with_block_transfers_top.sv
// Top level: ring FIFO of 64-bit words with single and block transfers.
//
// Request channel (in_valid/in_ready) carries command, item_value, block_len,
// up_to and block_first; result channel (out_valid/out_ready) carries
// read_value, status, granted and last. Every request gives one result,
// except a granted block read, which gives one result per word and sets
// last on the final one.
// Writes, block write elements and refusals load the result register on
// acceptance; a single read first passes the registered read port of the
// ring memory. Writes and refusals are taken one request per cycle while
// results drain; a single read keeps the controller busy until it is loaded,
// and a block read streams its words, each a memory read, then a load into
// the result register, pausing while the result register is occupied.
// A request is taken whenever the controller is idle and the result register
// is empty or being drained in the same cycle, so a stalled receiver holds
// back new requests only once the result register is occupied.
// Capacity (cfg_wr_en/cfg_wr_data) saturates into 1..DEPTH and empties the
// ring; write it only when idle.
// Reset empties the ring, clears the block write grant and sets capacity to
// DEPTH. Ring contents are not cleared.
module ring_fifo_with_block_transfers_top #(
	parameter int DEPTH = rfbt_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rfbt_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [rfbt_pkg::WORD_W-1:0] item_value,
	input  logic [rfbt_pkg::CNT_W-1:0]  block_len,
	input  logic                        up_to,
	input  logic                        block_first,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rfbt_pkg::WORD_W-1:0] read_value,
	output logic                        status,
	output logic [rfbt_pkg::CNT_W-1:0]  granted,
	output logic                        last
);

	rfbt_pkg::ctrl_cmd_t cmd;
	rfbt_pkg::dp_stat_t  stat;

	// Sequencing of requests and block reads
	rfbt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.block_first (block_first),
		.stat        (stat),
		.cmd         (cmd)
	);

	// Ring storage, pointers, grants and the result register
	rfbt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_value  (item_value),
		.block_len   (block_len),
		.up_to       (up_to),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.read_value  (read_value),
		.status      (status),
		.granted     (granted),
		.last        (last)
	);

endmodule

// File: bench/ring_fifo_with_block_transfers_checker.sv
// Response predictor and scoreboard for the ring FIFO with block transfers.
module ring_fifo_with_block_transfers_checker #(
	parameter int DEPTH = rfbt_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rfbt_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [rfbt_pkg::WORD_W-1:0] item_value,
	input  logic [rfbt_pkg::CNT_W-1:0]  block_len,
	input  logic                        up_to,
	input  logic                        block_first,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [rfbt_pkg::WORD_W-1:0] read_value,
	input  logic                        status,
	input  logic [rfbt_pkg::CNT_W-1:0]  granted,
	input  logic                        last,
	output int                          error_count,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic RESP_OK      = 1'b0;
	localparam logic RESP_REFUSED = 1'b1;

	typedef struct packed {
		logic [rfbt_pkg::WORD_W-1:0] value;
		logic                        status;
		logic [rfbt_pkg::CNT_W-1:0]  granted;
		logic                        last;
	} response_t;

	response_t                   due_responses[$];
	logic [rfbt_pkg::WORD_W-1:0] ring_mem[DEPTH];
	int unsigned                 rd_ptr;
	int unsigned                 wr_ptr;
	int unsigned                 occupancy;
	int unsigned                 paste_left;
	int unsigned                 cap;

	function automatic int unsigned step_ptr(int unsigned p);
		return (p + 1 >= cap) ? 0 : p + 1;
	endfunction

	// Count a block request gets against 'avail' entries; zero means refused.
	function automatic int unsigned block_grant(int unsigned len, bit upto,
			int unsigned avail);
		if (len == 0)
			return 0;
		if (!upto)
			return (len > cap || len > avail) ? 0 : len;
		return (len < avail) ? len : avail;
	endfunction

	task automatic add_response(logic [rfbt_pkg::WORD_W-1:0] v, logic st,
			int unsigned g, logic lst);
		response_t r;
		r.value   = v;
		r.status  = st;
		r.granted = g[rfbt_pkg::CNT_W-1:0];
		r.last    = lst;
		due_responses.push_back(r);
	endtask

	task automatic store_word(logic [rfbt_pkg::WORD_W-1:0] v);
		ring_mem[wr_ptr] = v;
		wr_ptr = step_ptr(wr_ptr);
		occupancy++;
	endtask

	task automatic take_word(output logic [rfbt_pkg::WORD_W-1:0] v);
		v = ring_mem[rd_ptr];
		rd_ptr = step_ptr(rd_ptr);
		occupancy--;
	endtask

	task automatic ring_update(rfbt_pkg::cmd_t c, logic [rfbt_pkg::WORD_W-1:0] v,
			int unsigned len, bit upto, bit fst);
		int unsigned                 n;
		logic [rfbt_pkg::WORD_W-1:0] w;
		// anything but a block write element closes an open block write
		if (c != rfbt_pkg::CMD_BLOCK_WRITE)
			paste_left = 0;
		case (c)
			rfbt_pkg::CMD_WRITE_ONE: begin
				if (v == '0 || occupancy >= cap) begin
					add_response('0, RESP_REFUSED, 0, 1'b1);
				end else begin
					store_word(v);
					add_response('0, RESP_OK, 0, 1'b1);
				end
			end
			rfbt_pkg::CMD_READ_ONE: begin
				if (occupancy == 0) begin
					add_response('0, RESP_REFUSED, 0, 1'b1);
				end else begin
					take_word(w);
					add_response(w, RESP_OK, 0, 1'b1);
				end
			end
			rfbt_pkg::CMD_BLOCK_READ: begin
				n = block_grant(len, upto, occupancy);
				if (n == 0)
					add_response('0, RESP_REFUSED, 0, 1'b1);
				for (int unsigned k = 0; k < n; k++) begin
					take_word(w);
					add_response(w, RESP_OK, n, k + 1 == n);
				end
			end
			default: begin
				if (fst) begin
					n = block_grant(len, upto, cap - occupancy);
					if (n == 0) begin
						paste_left = 0;
						add_response('0, RESP_REFUSED, 0, 1'b1);
					end else begin
						store_word(v);
						paste_left = n - 1;
						add_response('0, RESP_OK, n, 1'b1);
					end
				end else if (paste_left == 0 || occupancy >= cap) begin
					paste_left = 0;
					add_response('0, RESP_REFUSED, 0, 1'b1);
				end else begin
					store_word(v);
					paste_left--;
					add_response('0, RESP_OK, 0, 1'b1);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			due_responses.delete();
			rd_ptr      = 0;
			wr_ptr      = 0;
			occupancy   = 0;
			paste_left  = 0;
			cap         = DEPTH;
			error_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_responses.size() == 0) begin
					$error("response with none expected: %h status %b granted %0d last %b",
						read_value, status, granted, last);
					error_count++;
				end else begin
					want = due_responses.pop_front();
					if (read_value !== want.value) begin
						$error("read_value mismatch: expected %h, got %h", want.value, read_value);
						error_count++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %b, got %b", want.status, status);
						error_count++;
					end
					if (granted !== want.granted) begin
						$error("granted mismatch: expected %0d, got %0d", want.granted, granted);
						error_count++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %b, got %b", want.last, last);
						error_count++;
					end
				end
			end
			// capacity write saturates and empties the ring
			if (cfg_wr_en) begin
				if (cfg_wr_data == 0)
					cap = 1;
				else if (cfg_wr_data > DEPTH)
					cap = DEPTH;
				else
					cap = cfg_wr_data;
				rd_ptr     = 0;
				wr_ptr     = 0;
				occupancy  = 0;
				paste_left = 0;
			end
			if (in_valid && in_ready)
				ring_update(rfbt_pkg::cmd_t'(command), item_value, block_len, up_to,
					block_first);
		end
		outstanding = due_responses.size();
	end

endmodule

// File: bench/ring_fifo_with_block_transfers_top_tb.sv
// Testbench top: clock, reset, request stimulus, capacity phases and verdict.
module ring_fifo_with_block_transfers_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous cycle ceiling; a normal run needs a small fraction of it.
	localparam int CYCLE_LIMIT = 1000000;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [rfbt_pkg::CNT_W-1:0]  cfg_wr_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [1:0]                  command;
	logic [rfbt_pkg::WORD_W-1:0] item_value;
	logic [rfbt_pkg::CNT_W-1:0]  block_len;
	logic                        up_to;
	logic                        block_first;
	logic                        out_valid;
	logic                        out_ready;
	logic [rfbt_pkg::WORD_W-1:0] read_value;
	logic                        status;
	logic [rfbt_pkg::CNT_W-1:0]  granted;
	logic                        last;

	int error_count;
	int outstanding;
	int cycle_count = 0;
	int requests_sent = 0;
	// percent of cycles the request side sits idle / the response side stalls
	int idle_pct = 0;
	int stall_pct = 0;

	ring_fifo_with_block_transfers_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.item_value  (item_value),
		.block_len   (block_len),
		.up_to       (up_to),
		.block_first (block_first),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.status      (status),
		.granted     (granted),
		.last        (last)
	);

	ring_fifo_with_block_transfers_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.item_value  (item_value),
		.block_len   (block_len),
		.up_to       (up_to),
		.block_first (block_first),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.status      (status),
		.granted     (granted),
		.last        (last),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Response-side backpressure, redrawn every falling edge. Held low in reset.
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [rfbt_pkg::WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic bit rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Mostly short transfers, sometimes any legal length, now and then the full 64.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 90)
			return $urandom_range(0, 64);
		return 64;
	endfunction

	// Present one request and hold it until accepted. Called and returns on a
	// falling edge; valid stays up between back-to-back requests.
	task automatic send(rfbt_pkg::cmd_t c, logic [rfbt_pkg::WORD_W-1:0] v, int len,
			bit ut, bit fst);
		int gap;
		gap = 0;
		while (idle_pct != 0 && gap < 40 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command     = c;
		item_value  = v;
		block_len   = rfbt_pkg::CNT_W'(len);
		up_to       = ut;
		block_first = fst;
		in_valid    = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Drop valid, let every predicted response drain, then let the block sit
	// idle before touching capacity.
	task automatic settle();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_capacity(int v);
		cfg_wr_data = rfbt_pkg::CNT_W'(v);
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// Random traffic. Block writes come mostly as proper sequences: a first
	// element followed by roughly the requested length in elements, sometimes
	// short, sometimes overrunning the grant. Stray elements and zero words
	// are mixed in as noise.
	task automatic random_traffic(int n);
		int          target;
		int          r;
		int          len;
		int          extra;
		int          lo;
		logic [63:0] w;
		target = requests_sent + n;
		while (requests_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				w = ($urandom_range(0, 9) == 0) ? '0 : rand_word();
				send(rfbt_pkg::CMD_WRITE_ONE, w, $urandom_range(0, 64), rand_bit(),
					rand_bit());
			end else if (r < 45) begin
				send(rfbt_pkg::CMD_READ_ONE, rand_word(), $urandom_range(0, 64), rand_bit(),
					rand_bit());
			end else if (r < 60) begin
				send(rfbt_pkg::CMD_BLOCK_READ, rand_word(), pick_len(), rand_bit(),
					rand_bit());
			end else if (r < 92) begin
				len = pick_len();
				send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), len, rand_bit(), 1'b1);
				lo = (len > 2) ? len - 2 : 0;
				extra = $urandom_range(lo, len + 1);
				for (int j = 0; j < extra; j++) begin
					w = ($urandom_range(0, 9) == 0) ? '0 : rand_word();
					send(rfbt_pkg::CMD_BLOCK_WRITE, w, $urandom_range(0, 64), rand_bit(),
						1'b0);
				end
			end else begin
				// element with no block write open
				send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), $urandom_range(0, 64),
					rand_bit(), 1'b0);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		command     = rfbt_pkg::CMD_WRITE_ONE;
		item_value  = '0;
		block_len   = '0;
		up_to       = 1'b0;
		block_first = 1'b0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- Directed requests at reset capacity (64), no idling ----
		// read and block read on an empty ring are refused
		send(rfbt_pkg::CMD_READ_ONE, '0, 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 3, 1'b1, 1'b0);
		// a zero word is refused; all-ones and one go in
		send(rfbt_pkg::CMD_WRITE_ONE, '0, 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_WRITE_ONE, '1, 64, 1'b1, 1'b1);
		send(rfbt_pkg::CMD_WRITE_ONE, 64'h1, 0, 1'b0, 1'b0);
		// zero-length block, and all-or-nothing asking for more than stored
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 0, 1'b1, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 3, 1'b0, 1'b0);
		// up-to block read takes both words, last on the second
		send(rfbt_pkg::CMD_BLOCK_READ, '1, 64, 1'b1, 1'b1);
		// block write: zero length refused, stray element dropped
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 0, 1'b1, 1'b1);
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 5, 1'b0, 1'b0);
		// full-ring grant; a zero word is legal inside a block write
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 64, 1'b0, 1'b1);
		send(rfbt_pkg::CMD_BLOCK_WRITE, '0, 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 0, 1'b0, 1'b0);
		// any other command closes the open block write; grant is lost
		send(rfbt_pkg::CMD_WRITE_ONE, rand_word(), 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 64, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 4, 1'b0, 1'b0);
		settle();

		// ---- Capacity 0 saturates to 1: full ring and over-capacity cases ----
		write_capacity(0);
		send(rfbt_pkg::CMD_WRITE_ONE, rand_word(), 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_WRITE_ONE, rand_word(), 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 1, 1'b1, 1'b1);
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 2, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_READ_ONE, '0, 0, 1'b0, 1'b0);
		// up-to write trimmed to the single free entry, so the next one drops
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 5, 1'b1, 1'b1);
		send(rfbt_pkg::CMD_BLOCK_WRITE, rand_word(), 0, 1'b0, 1'b0);
		send(rfbt_pkg::CMD_BLOCK_READ, '0, 1, 1'b0, 1'b0);
		random_traffic(35);
		settle();

		// ---- 127 saturates to the full depth; sender mostly idle ----
		write_capacity(127);
		idle_pct  = 75;
		stall_pct = 0;
		random_traffic(40);
		settle();

		// ---- Small ring, receiver mostly stalled ----
		write_capacity(6);
		idle_pct  = 0;
		stall_pct = 75;
		random_traffic(40);
		settle();

		// ---- Mid-size ring, light idling on both sides ----
		write_capacity(33);
		idle_pct  = 12;
		stall_pct = 12;
		random_traffic(35);
		settle();

		// ---- Full depth again, back to back ----
		write_capacity(64);
		idle_pct  = 0;
		stall_pct = 0;
		random_traffic(35);
		settle();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
